// ===== rtl/mbps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_pkg - shared types and constants of the masked byte pattern search
// Register map codes, field widths and the signature configuration bundle.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int unsigned SigBytes = 16;
  localparam int unsigned LenW     = 5;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned RegIdxW  = 3;

  localparam logic [RegIdxW-1:0] RegPatLow  = 3'd0;
  localparam logic [RegIdxW-1:0] RegPatHigh = 3'd1;
  localparam logic [RegIdxW-1:0] RegCare    = 3'd2;
  localparam logic [RegIdxW-1:0] RegLength  = 3'd3;
  localparam logic [RegIdxW-1:0] RegBase    = 3'd4;

  typedef struct packed {
    logic [SigBytes*8-1:0] sig;
    logic [SigBytes-1:0]   care;
  } pat_cfg_t;

endpackage

// ===== rtl/mbps_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_match - window compare
// Compares the newest bytes of the stream with the signature, end aligned to
// the current byte, honouring care bits; byte 0 is always compared.
// ----------------------------------------------------------------------------
module mbps_match
  import mbps_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  logic [7:0]      hist_i [MAX_PATTERN],
  input  pat_cfg_t        cfg_i,
  input  logic [LenW-1:0] len_i,
  output logic            match_o
);

  logic [7:0]      sel_byte  [MAX_PATTERN];
  logic [LenW-1:0] back_dist [MAX_PATTERN];

  always_comb begin
    match_o = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      back_dist[k] = len_i - LenW'(k) - LenW'(1);
      sel_byte[k]  = '0;
      for (int d = 0; d < MAX_PATTERN; d++) begin
        if (back_dist[k] == LenW'(d)) begin
          sel_byte[k] = sel_byte[k] | hist_i[d];
        end
      end
      if ((LenW'(k) < len_i) && ((k == 0) || cfg_i.care[k]) &&
          (sel_byte[k] != cfg_i.sig[k*8 +: 8])) begin
        match_o = 1'b0;
      end
    end
  end

endmodule

// ===== rtl/masked_byte_pattern_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_search - streaming masked signature search
// Bytes of a region enter on s_axis (tlast marks the region's last byte).
// One result per region leaves on m_axis: the address of the first match
// lying wholly inside the region, as soon as its last byte arrives, or a
// not-found result on the region's last byte. The block takes one byte per
// clock while the result side can take results; an item passes an input
// register and a result register. The rate is set by the window compare,
// done in parallel over all signature bytes. The user writes registers over
// APB only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search
  import mbps_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [0] found, [32:1] match_address, zeros
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int unsigned WinDepth = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;

  // configuration
  logic [63:0]        pat_lo_q, pat_hi_q;
  logic [15:0]        care_q;
  logic [LenW-1:0]    len_q;
  logic [AddrW-1:0]   base_q;
  logic               cfg_wr;
  logic [RegIdxW-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      care_q   <= '1;
      len_q    <= LenW'(1);
      base_q   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegPatLow:  pat_lo_q <= pwdata;
        RegPatHigh: pat_hi_q <= pwdata;
        RegCare:    care_q   <= pwdata[15:0];
        RegLength:  len_q    <= pwdata[LenW-1:0];
        RegBase:    base_q   <= pwdata[AddrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegPatLow:  prdata = pat_lo_q;
      RegPatHigh: prdata = pat_hi_q;
      RegCare:    prdata = {48'd0, care_q};
      RegLength:  prdata = {59'd0, len_q};
      RegBase:    prdata = {32'd0, base_q};
      default:    prdata = '0;
    endcase
  end

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_free, fire0;

  assign out_free      = ~m_axis_tvalid | m_axis_tready;
  assign fire0         = in_vld_q & out_free;
  assign s_axis_tready = ~in_vld_q | fire0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // region state
  logic [7:0]       win_q [WinDepth];
  logic [AddrW-1:0] cnt_q, cnt_next;
  logic             found_q;
  logic [7:0]       hist [MAX_PATTERN];
  logic [LenW-1:0]  len_eff;
  logic             win_match, hit, miss, load_out;
  pat_cfg_t         pat_cfg;

  always_comb begin
    hist[0] = in_byte_q;
    for (int d = 1; d < MAX_PATTERN; d++) begin
      hist[d] = win_q[d-1];
    end
  end

  assign len_eff      = (len_q > LenW'(MAX_PATTERN)) ? LenW'(MAX_PATTERN) : len_q;
  assign cnt_next     = (cnt_q == '1) ? cnt_q : cnt_q + AddrW'(1);
  assign pat_cfg.sig  = {pat_hi_q, pat_lo_q};
  assign pat_cfg.care = care_q;

  mbps_match #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_match (
    .hist_i (hist),
    .cfg_i  (pat_cfg),
    .len_i  (len_eff),
    .match_o(win_match)
  );

  assign hit      = ~found_q & (len_eff != '0) & (cnt_next >= AddrW'(len_eff)) & win_match;
  assign miss     = ~hit & in_last_q & ~found_q;
  assign load_out = fire0 & (hit | miss);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      found_q <= 1'b0;
      for (int i = 0; i < WinDepth; i++) begin
        win_q[i] <= '0;
      end
    end else if (fire0) begin
      if (in_last_q) begin
        cnt_q   <= '0;
        found_q <= 1'b0;
        for (int i = 0; i < WinDepth; i++) begin
          win_q[i] <= '0;
        end
      end else begin
        cnt_q   <= cnt_next;
        found_q <= found_q | hit;
        win_q[0] <= in_byte_q;
        for (int i = 1; i < WinDepth; i++) begin
          win_q[i] <= win_q[i-1];
        end
      end
    end
  end

  // result register
  logic             res_found_q;
  logic [AddrW-1:0] res_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      res_found_q <= hit;
      res_addr_q  <= hit ? base_q + cnt_next - AddrW'(len_eff) : '0;
    end
  end

  assign m_axis_tdata = {7'd0, res_addr_q, res_found_q};

  // checks
  a_clear_on_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire0 && in_last_q) |=> (!found_q && cnt_q == '0))
    else $error("region state not cleared after last item");

  a_miss_on_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && !hit) |-> in_last_q)
    else $error("not-found result away from region end");

  a_no_double : assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> !hit)
    else $error("second match reported in one region");

  a_miss_addr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[32:1] == '0))
    else $error("not-found result carries an address");

  a_stall_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_vld_q && !out_free))
    else $error("input stalled without cause");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - masked byte pattern search
// Streams regions of bytes into the search block and checks every result
// against a predictor that keeps its own copy of the signature registers,
// the byte history and the per-region match state. A short directed run
// covers the reset settings, wildcards, zero and oversized lengths, matches
// that start in an earlier region, bytes after a match and address wrap.
// Random phases then follow under changing settings, with both stream sides
// stalling at random but for the oversized-length phase.
// ----------------------------------------------------------------------------
module testbench;
  import mbps_pkg::*;

  localparam int unsigned IdlePct       = 29;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned PhaseBytes    = 70;
  localparam int unsigned NumPhases     = 8;
  localparam logic [7:0]  WildChar      = 8'h3F;

  typedef struct packed {
    logic             found;
    logic [AddrW-1:0] addr;
  } search_result_t;

  class search_scoreboard;
    logic [63:0]         sig_lo;
    logic [63:0]         sig_hi;
    logic [SigBytes-1:0] care;
    logic [LenW-1:0]     len_reg;
    logic [AddrW-1:0]    base;
    logic [7:0]          history [SigBytes-1];
    logic [31:0]         seen;
    bit                  reported;
    search_result_t      expected_q[$];
    int unsigned         errors;
    int unsigned         hits;
    int unsigned         misses;
    int unsigned         regions;

    function new();
      sig_lo   = '0;
      sig_hi   = '0;
      care     = '1;
      len_reg  = LenW'(1);
      base     = '0;
      seen     = '0;
      reported = 1'b0;
      foreach (history[i]) history[i] = '0;
    endfunction

    function void write_reg(logic [RegIdxW-1:0] idx, logic [63:0] value);
      case (idx)
        RegPatLow:  sig_lo = value;
        RegPatHigh: sig_hi = value;
        RegCare:    care = value[SigBytes-1:0];
        RegLength:  len_reg = value[LenW-1:0];
        RegBase:    base = value[AddrW-1:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] sig_byte(int unsigned k);
      if (k < 8) return sig_lo[8*k +: 8];
      return sig_hi[8*(k-8) +: 8];
    endfunction

    function int unsigned active_len();
      return (len_reg > SigBytes) ? SigBytes : len_reg;
    endfunction

    function bit window_hits(logic [7:0] cur, int unsigned n);
      int unsigned d;
      logic [7:0]  back;
      for (int unsigned k = 0; k < n; k++) begin
        d = n - 1 - k;
        back = (d == 0) ? cur : history[d-1];
        if ((k == 0 || care[k]) && back != sig_byte(k)) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_byte(logic [7:0] cur, logic last);
      int unsigned    n;
      search_result_t res;
      n = active_len();
      if (seen != 32'hFFFF_FFFF) seen++;
      if (!reported && n != 0 && seen >= n && window_hits(cur, n)) begin
        reported = 1'b1;
        res.found = 1'b1;
        res.addr = AddrW'(base + seen - n);
        expected_q.push_back(res);
      end else if (last && !reported) begin
        res = '0;
        expected_q.push_back(res);
      end
      if (last) begin
        foreach (history[i]) history[i] = '0;
        seen = '0;
        reported = 1'b0;
        regions++;
      end else begin
        for (int i = SigBytes - 2; i > 0; i--) history[i] = history[i-1];
        history[0] = cur;
      end
    endfunction

    function void report(string what, logic [AddrW-1:0] want, logic [AddrW-1:0] got);
      $display("mismatch at %0t: %s, expected %0h, got %0h", $realtime, what, want, got);
      errors++;
    endfunction

    function void check_result(logic found, logic [AddrW-1:0] addr);
      search_result_t want;
      if (expected_q.size() == 0) begin
        report("result with nothing expected", '0, AddrW'(found));
        return;
      end
      want = expected_q.pop_front();
      if (found !== want.found) report("found flag", AddrW'(want.found), AddrW'(found));
      if (addr !== want.addr) report("match address", want.addr, addr);
      if (want.found) hits++;
      else misses++;
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  search_scoreboard sb;
  bit               no_idle;
  int unsigned      quiet_cycles;
  int unsigned      bytes_sent;
  int unsigned      settings;

  always #1 clk_i = ~clk_i;

  masked_byte_pattern_search dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] data_byte
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [0] found, [32:1] match_address, zeros
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tlast);
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata[0], m_axis_tdata[32:1]);
  end

  always @(negedge clk_i) begin
    m_axis_tready <= no_idle || ($urandom_range(99) >= IdlePct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no item moved for %0d cycles", quiet_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic apb_write(logic [RegIdxW-1:0] idx, logic [63:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_search(logic [63:0] lo, logic [63:0] hi, logic [63:0] care,
                                logic [63:0] len, logic [63:0] base);
    apb_write(RegPatLow, lo);
    apb_write(RegPatHigh, hi);
    apb_write(RegCare, care);
    apb_write(RegLength, len);
    apb_write(RegBase, base);
    settings++;
  endtask

  // drop valid, wait for every result, then let the pipeline drain
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send_region(int unsigned n, int unsigned mode);
    logic [7:0]  q[$];
    int unsigned eff;
    int unsigned pos;
    int unsigned k;
    eff = sb.active_len();
    for (int unsigned i = 0; i < n; i++)
      q.push_back((mode != 0 && $urandom_range(1)) ? sb.sig_byte($urandom_range(SigBytes-1))
                                                   : 8'($urandom_range(255)));
    if (mode == 2 && eff != 0) begin
      if (n >= eff && $urandom_range(3) != 0) pos = $urandom_range(n - eff);
      else pos = $urandom_range(n - 1);
      for (k = 0; k < eff && pos + k < n; k++)
        if (k == 0 || sb.care[k]) q[pos+k] = sb.sig_byte(k);
      if ($urandom_range(3) == 0) begin
        k = $urandom_range(eff - 1);
        if (pos + k < n) q[pos+k] = q[pos+k] ^ (8'h01 << $urandom_range(7));
      end
    end
    for (int unsigned i = 0; i < n; i++) send_byte(q[i], i == n - 1);
  endtask

  task automatic random_phase(int unsigned phase);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] care;
    logic [63:0] len;
    logic [63:0] base;
    int unsigned start;
    int unsigned r;
    lo   = {$urandom, $urandom};
    hi   = {$urandom, $urandom};
    care = 64'($urandom_range(16'hFFFF));
    len  = 64'($urandom_range(1, SigBytes));
    base = 64'($urandom);
    case (phase)
      0: begin
        len  = 64'(SigBytes);
        care = 64'hFFFF;
      end
      1: len = 64'd1;
      2: len = 64'd0;
      3: len = 64'($urandom_range(SigBytes + 1, 31));
      4: begin
        len  = 64'd2;
        care = 64'd0;
      end
      5: base = 64'hFFFF_FFF0;
      6: begin
        lo   = '0;
        hi   = '0;
        base = '0;
      end
      7: begin
        lo = '1;
        hi = '1;
      end
      default: ;
    endcase
    program_search(lo, hi, care, len, base);
    no_idle = (phase == 3);
    start = bytes_sent;
    while (bytes_sent - start < PhaseBytes) begin
      r = $urandom_range(99);
      send_region(($urandom_range(9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20),
                  (r < 15) ? 0 : (r < 30) ? 1 : 2);
    end
    settle();
    no_idle = 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: one-byte signature of zero
    send_byte(8'h05, 1'b0);
    send_byte(8'h00, 1'b1);
    settle();

    for (int idx = RegBase + 1; idx < (1 << RegIdxW); idx++)
      apb_write(RegIdxW'(idx), {$urandom, $urandom});

    // "A?C" with the middle byte a wildcard; upper value bits are masked
    program_search({40'h0, 8'h43, WildChar, 8'h41}, 64'h0, 64'hFFFF_FFFF_FFFF_FFFD,
                   64'hFFFF_FFFF_FFFF_FFE3, 64'hDEAD_BEEF_0000_1000);
    send_byte(8'h41, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(8'h43, 1'b0);
    send_byte(8'h5A, 1'b1);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b1);
    send_byte(8'h43, 1'b1);
    settle();

    apb_write(RegLength, 64'h0);
    send_byte(8'h41, 1'b1);
    settle();

    // oversized length, match on the last byte, address wraps to zero
    program_search('1, '0, 64'hFFFF, 64'd31, 64'hFFFF_FFFF);
    send_byte(8'h12, 1'b0);
    for (int i = 0; i < SigBytes; i++) send_byte((i < 8) ? 8'hFF : 8'h00, i == SigBytes - 1);
    settle();

    for (int unsigned phase = 0; phase < NumPhases; phase++) random_phase(phase);

    $display("run covered %0d bytes in %0d regions under %0d register settings",
             bytes_sent, sb.regions, settings);
    $display("checked %0d matches and %0d empty regions, %0d mismatches",
             sb.hits, sb.misses, sb.errors);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
